// ===== rtl/core/stree_pkg.sv =====
// Shared constants, command and status types for the segment tree range sum block.
package stree_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int NODE_W       = IDX_W + 1;
  localparam int NODES        = 2 * MAX_ELEMENTS;
  localparam int BND_W        = NODE_W + 1;
  localparam int VAL_W        = 32;
  localparam int SUM_W        = 42;
  localparam int CNT_W        = 11;
  localparam int CNT_RESET    = 1024;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 48;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_UPD_WR,
    ST_UPD_SUM,
    ST_QRY_A,
    ST_QRY_B,
    ST_DONE
  } stree_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic clr_step;
    logic upd_write;
    logic upd_sum;
    logic qry_a;
    logic qry_b;
    logic out_load;
  } stree_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_upd;
    logic upd_bad;
    logic qry_empty;
    logic node_root;
    logic a_lt_b;
    logic out_free;
  } stree_status_t;

endpackage

// ===== rtl/core/stree_ctrl.sv =====
// Sequencer for clearing, updates and queries of the segment tree.
module stree_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  stree_pkg::stree_status_t sts,
  output stree_pkg::stree_cmd_t    cmd
);

  stree_pkg::stree_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stree_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      stree_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = stree_pkg::ST_IDLE;
      end
      stree_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stree_pkg::ST_SETUP;
        end
      end
      stree_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_upd && !sts.upd_bad) state_next = stree_pkg::ST_UPD_WR;
        else if (!sts.is_upd && !sts.qry_empty) state_next = stree_pkg::ST_QRY_A;
        else state_next = stree_pkg::ST_DONE;
      end
      // write node, fetch its sibling
      stree_pkg::ST_UPD_WR: begin
        cmd.upd_write = 1'b1;
        state_next = sts.node_root ? stree_pkg::ST_DONE : stree_pkg::ST_UPD_SUM;
      end
      stree_pkg::ST_UPD_SUM: begin
        cmd.upd_sum = 1'b1;
        state_next  = stree_pkg::ST_UPD_WR;
      end
      // left boundary of the current level
      stree_pkg::ST_QRY_A: begin
        if (sts.a_lt_b) begin
          cmd.qry_a  = 1'b1;
          state_next = stree_pkg::ST_QRY_B;
        end else begin
          state_next = stree_pkg::ST_DONE;
        end
      end
      // right boundary, then climb one level
      stree_pkg::ST_QRY_B: begin
        cmd.qry_b  = 1'b1;
        state_next = stree_pkg::ST_QRY_A;
      end
      stree_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = stree_pkg::ST_IDLE;
        end
      end
      default: state_next = stree_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/stree_dp.sv =====
// Datapath: node memory, walk registers, accumulator, count register and result register.
module stree_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  stree_pkg::stree_cmd_t                  cmd,
  output stree_pkg::stree_status_t               sts,
  input  logic                                   cfg_wen,
  input  logic [stree_pkg::CNT_W-1:0]            cfg_wdata,
  input  logic                                   in_command,
  input  logic [stree_pkg::IDX_W-1:0]            in_left,
  input  logic [stree_pkg::IDX_W-1:0]            in_right,
  input  logic [stree_pkg::IDX_W-1:0]            in_pos,
  input  logic signed [stree_pkg::VAL_W-1:0]     in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [stree_pkg::SUM_W-1:0]     out_sum,
  output logic                                   out_status
);

  localparam int NODE_W = stree_pkg::NODE_W;
  localparam int BND_W  = stree_pkg::BND_W;
  localparam int SUM_W  = stree_pkg::SUM_W;
  localparam int CNT_W  = stree_pkg::CNT_W;
  localparam int IDX_W  = stree_pkg::IDX_W;

  logic [SUM_W-1:0] mem [stree_pkg::NODES];
  logic [SUM_W-1:0] rdata;

  logic [CNT_W-1:0]  count;
  logic [NODE_W-1:0] clr_cnt;
  logic              rd_pend;

  logic              cmd_r;
  logic [IDX_W-1:0]  left_r, right_r, pos_r;
  logic [stree_pkg::VAL_W-1:0] value_r;

  logic [NODE_W-1:0] node;
  logic [SUM_W-1:0]  cur;
  logic [SUM_W-1:0]  acc;
  logic [BND_W-1:0]  a, b;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  hi;
  logic [BND_W-1:0]  b_dec;
  logic [BND_W-1:0]  b_sel;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic [NODE_W-1:0] rd_addr;
  logic              rd_issue;

  // effective count and range bounds
  always_comb begin
    n_eff = (count > CNT_W'(stree_pkg::MAX_ELEMENTS)) ?
            CNT_W'(stree_pkg::MAX_ELEMENTS) : count;
    hi    = ({1'b0, right_r} >= n_eff) ? (n_eff - CNT_W'(1)) : {1'b0, right_r};
    b_dec = b - BND_W'(1);
    b_sel = b[0] ? b_dec : b;
  end

  // status to controller
  always_comb begin
    sts.clr_last  = (clr_cnt == NODE_W'(stree_pkg::NODES - 1));
    sts.is_upd    = (cmd_r == stree_pkg::CMD_UPDATE);
    sts.upd_bad   = ({1'b0, pos_r} >= n_eff);
    sts.qry_empty = (left_r > right_r) || ({1'b0, left_r} >= n_eff);
    sts.node_root = (node == NODE_W'(1));
    sts.a_lt_b    = (a < b);
    sts.out_free  = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    wr_en   = cmd.clr_step || cmd.upd_write;
    wr_addr = cmd.clr_step ? clr_cnt : node;
    wr_data = cmd.clr_step ? '0 : cur;
    if (cmd.qry_a) rd_addr = a[NODE_W-1:0];
    else if (cmd.qry_b) rd_addr = b_dec[NODE_W-1:0];
    else rd_addr = node ^ NODE_W'(1);
    rd_issue = (cmd.qry_a && a[0]) || (cmd.qry_b && b[0]);
  end

  // node memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CNT_W'(stree_pkg::CNT_RESET);
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) count <= cfg_wdata;
      if (cmd.clr_step) clr_cnt <= clr_cnt + NODE_W'(1);
      rd_pend <= rd_issue;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      left_r  <= in_left;
      right_r <= in_right;
      pos_r   <= in_pos;
      value_r <= in_value;
    end
    if (cmd.setup) begin
      node <= {1'b1, pos_r};
      cur  <= SUM_W'(signed'(value_r));
      a    <= {2'b01, left_r};
      b    <= {1'b0, hi} + BND_W'(stree_pkg::MAX_ELEMENTS + 1);
      acc  <= '0;
    end else if (rd_pend) begin
      acc  <= acc + rdata;
    end
    if (cmd.upd_sum) begin
      cur  <= cur + rdata;
      node <= node >> 1;
    end
    if (cmd.qry_a && a[0]) a <= a + BND_W'(1);
    if (cmd.qry_b) begin
      a <= a >> 1;
      b <= b_sel >> 1;
    end
    if (cmd.out_load) begin
      out_sum    <= sts.is_upd ? '0 : acc;
      out_status <= sts.is_upd && sts.upd_bad;
    end
  end

  // checks
  a_no_pend_at_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |-> !rd_pend) else $error("read still pending at setup");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_write |-> node != '0) else $error("update walked past root");
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.qry_a || cmd.qry_b) |-> a <= b) else $error("query bounds crossed");

endmodule

// ===== rtl/core/segment_tree_range_sum.sv =====
// Top level of the segment tree range sum block: ports, word packing, controller and datapath.
//
// channel  | direction | handshake          | contents
// s_*      | in        | s_tvalid/s_tready  | tuser: command; tdata: left, right, update index, value
// m_*      | out       | m_tvalid/m_tready  | tuser: status; tdata: range sum
// cfg_*    | in        | cfg_wen            | element count
//
// After reset a clearing pass zeroes all 2048 tree nodes, with s_tready low.
// An update makes 11 node writes, leaf to root, with a sibling add between each.
// A query visits two boundary nodes per level, at most one memory read per cycle.
// Flagged updates and empty queries go from setup straight to the done step.
// A new word is taken while a result still waits in the output register; a stalled
// m_tready holds the block in its last step until the register frees.
module segment_tree_range_sum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [9:0] left_index, [19:10] right_index, [29:20] update_index, [61:30] new_value
  input  logic [stree_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] command
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [41:0] range_sum
  output logic [stree_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [0] status
  output logic                                 m_tuser,
  input  logic                                 cfg_wen,
  input  logic [stree_pkg::CNT_W-1:0]          cfg_wdata
);

  localparam int IDX_W = stree_pkg::IDX_W;
  localparam int VAL_W = stree_pkg::VAL_W;
  localparam int SUM_W = stree_pkg::SUM_W;

  stree_pkg::stree_cmd_t    cmd;
  stree_pkg::stree_status_t sts;
  logic signed [SUM_W-1:0]  out_sum;

  stree_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stree_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_command (s_tuser),
    .in_left    (s_tdata[IDX_W-1:0]),
    .in_right   (s_tdata[2*IDX_W-1:IDX_W]),
    .in_pos     (s_tdata[3*IDX_W-1:2*IDX_W]),
    .in_value   (s_tdata[3*IDX_W+VAL_W-1:3*IDX_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sum    (out_sum),
    .out_status (m_tuser)
  );

  // zero-fill result word to whole bytes
  assign m_tdata = {{(stree_pkg::OUT_DATA_W - SUM_W){1'b0}}, out_sum};

endmodule
